// ===== src/keyboard_matrix_change_tracker_assert.svh =====
// Assertion macros for the keyboard matrix change tracker top level.
`ifndef KEYBOARD_MATRIX_CHANGE_TRACKER_ASSERT_SVH
`define KEYBOARD_MATRIX_CHANGE_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define KMCT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmct assertion failed");

// Next-cycle implication, checked outside reset
`define KMCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmct assertion failed");

`endif

// ===== src/kmct_pkg.sv =====
// Shared constants, codes and types of the keyboard matrix change tracker.
package kmct_pkg;

    // Matrix geometry
    localparam int ROWS        = 4;
    localparam int COLS        = 14;
    localparam int SENSE_LINES = 7;
    localparam int SCAN_LINES  = 8;

    localparam int KEYS   = ROWS * COLS;
    localparam int KEY_W  = $clog2(KEYS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int LINE_W = $clog2(SCAN_LINES);

    // Controller event byte
    localparam int CODE_W    = 8;
    localparam int KEY_NUM_W = 7;
    localparam int PRESS_BIT = 7;
    localparam int QUO_W     = 4;
    localparam logic [KEY_NUM_W-1:0] DIGIT_BASE = KEY_NUM_W'(10);
    localparam logic [KEY_NUM_W-1:0] HALF_SPLIT = KEY_NUM_W'(3);

    // Modifier index registers
    localparam int IDX_W     = 6;
    localparam int MOD_COUNT = 5;

    // Configuration port
    localparam int CFG_IDX_W = 3;

    // Stream widths
    localparam int IN_FIELDS_W  = LINE_W + SENSE_LINES + CODE_W;
    localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ROW_W + COL_W + 1 + MOD_COUNT;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(SCAN_LINES - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_FN,
        CFG_SHIFT,
        CFG_CTRL,
        CFG_OPT,
        CFG_ALT
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT,
        ST_SCAN
    } state_t;

    // Change scanner status towards the controller
    typedef struct packed {
        logic             hit;
        logic             more;
        logic             pressed;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } scan_stat_t;

    // Key number mapper status towards the controller
    typedef struct packed {
        logic             busy;
        logic             done;
        logic             hit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } km_res_t;

endpackage

// ===== src/kmct_keymap.sv =====
// Serial key number mapper: splits a key number less one into tens and units by repeated subtraction.
module kmct_keymap
    import kmct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [KEY_NUM_W-1:0] key_num,
    output km_res_t              res
);

    logic [KEY_NUM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic                 run_reg, run_next;
    logic [QUO_W:0]       col_wide;

    // One subtraction of the base per cycle
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        run_next = run_reg;
        if (start)
        begin
            rem_next = key_num - KEY_NUM_W'(1);
            quo_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_reg >= DIGIT_BASE)
            begin
                rem_next = rem_reg - DIGIT_BASE;
                quo_next = quo_reg + QUO_W'(1);
            end
            else
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Two columns per ten keys, units above three in the odd column
    assign col_wide = {quo_reg, 1'b0} + (QUO_W+1)'(rem_reg > HALF_SPLIT);

    always_comb
    begin
        res.busy = run_reg;
        res.done = run_reg && (rem_reg < DIGIT_BASE);
        res.hit  = (int'(col_wide) < COLS);
        res.row  = rem_reg[ROW_W-1:0];
        res.col  = col_wide[COL_W-1:0];
    end

endmodule

// ===== src/kmct_scanner.sv =====
// Bit-serial change scanner: walks the changed-key mask one key per cycle while advanced, row by row.
module kmct_scanner
    import kmct_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic [KEYS-1:0] diff,
    input  logic [KEYS-1:0] new_map,
    input  logic            advance,
    output scan_stat_t      stat
);

    logic [KEYS-1:0]  diff_reg, diff_next;
    logic [KEYS-1:0]  new_reg, new_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    // Load both masks, or shift both masks down and step the key position
    always_comb
    begin
        diff_next = diff_reg;
        new_next  = new_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (load)
        begin
            diff_next = diff;
            new_next  = new_map;
            row_next  = '0;
            col_next  = '0;
        end
        else if (advance)
        begin
            diff_next = diff_reg >> 1;
            new_next  = new_reg >> 1;
            if (col_reg == COL_W'(COLS - 1))
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg <= '0;
        end
        else
        begin
            diff_reg <= diff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        row_reg <= row_next;
        col_reg <= col_next;
    end

    always_comb
    begin
        stat.hit     = diff_reg[0];
        stat.more    = |diff_reg[KEYS-1:1];
        stat.pressed = new_reg[0];
        stat.row     = row_reg;
        stat.col     = col_reg;
    end

endmodule

// ===== src/keyboard_matrix_change_tracker.sv =====
// Top level of the keyboard matrix change tracker: bitmap, scan accumulator, control and output beat.
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------------------
//  s_axis  | s_axis_tvalid/tready     | tdata: scan_index, sense_levels, event_code
//  m_axis  | m_axis_tvalid/tready     | tdata: row, col, pressed, five flags; tlast
//  cfg     | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// A scan line other than the last leaves the controller idle. The last scan line, if it
// changes the bitmap, starts the serial change scanner, which steps one key per cycle while
// no changed key waits on a stalled output beat, ending after the last changed key. An event
// byte is accepted, mapped in the subtract-ten mapper and a result inside the matrix loaded.
// Reset clears the bitmap, the accumulator and the control and modifier index registers; no clearing pass.
// The next input beat is taken as soon as the last result sits in the output register.
module keyboard_matrix_change_tracker
    import kmct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [2:0] scan_index, [9:3] sense_levels, [17:10] event_code, rest zero
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] key_row, [5:2] key_col, [6] pressed, [7] fn_held, [8] shift_held,
    // [9] ctrl_held, [10] opt_held, [11] alt_held, rest zero
    output logic [OUT_W-1:0]     m_axis_tdata,
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IDX_W-1:0]     cfg_data
);

`include "keyboard_matrix_change_tracker_assert.svh"

    state_t                state_reg, state_next;
    logic [KEYS-1:0]       acc_reg, acc_next;
    logic [KEYS-1:0]       bitmap_reg, bitmap_next;
    logic                  mode_reg;
    logic [IDX_W-1:0]      mod_idx_reg [MOD_COUNT];
    logic [ROW_W-1:0]      evt_row_reg;
    logic [COL_W-1:0]      evt_col_reg;
    logic                  evt_pr_reg;
    logic                  out_valid_reg;
    logic                  out_last_reg;
    logic [OUT_FIELDS_W-1:0] out_data_reg;

    logic [LINE_W-1:0]      in_line;
    logic [SENSE_LINES-1:0] in_sense;
    logic [CODE_W-1:0]      in_code;
    logic                   in_fire;
    logic                   cfg_fire;
    logic                   slot_free;
    logic                   key_zero;
    logic [KEYS-1:0]        acc_line;
    logic [KEYS-1:0]        acc_new;
    logic [ROW_W-1:0]       line_row;
    logic                   line_odd;
    logic                   km_start;
    logic                   scan_load;
    logic                   scan_adv;
    logic                   out_load;
    logic                   out_last_in;
    logic [ROW_W-1:0]       out_row_in;
    logic [COL_W-1:0]       out_col_in;
    logic                   out_pr_in;
    logic [MOD_COUNT-1:0]   held_flags;
    logic [KEY_W-1:0]       evt_pos;
    km_res_t                km;
    scan_stat_t             scan;

    function automatic logic held(input logic [KEYS-1:0] map, input logic [IDX_W-1:0] idx);
        logic res;
        res = 1'b0;
        if (int'(idx) < KEYS)
        begin
            res = map[idx[KEY_W-1:0]];
        end
        return res;
    endfunction

    // Beat fields
    assign in_line  = s_axis_tdata[LINE_W-1:0];
    assign in_sense = s_axis_tdata[LINE_W +: SENSE_LINES];
    assign in_code  = s_axis_tdata[LINE_W + SENSE_LINES +: CODE_W];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign key_zero  = (in_code[KEY_NUM_W-1:0] == '0);

    // Bits of one scan line placed into the flat bitmap
    assign line_row = ROW_W'(ROWS - 1) - in_line[ROW_W-1:0];
    assign line_odd = !in_line[LINE_W-1];

    always_comb
    begin
        int c;
        int pos;
        acc_line = '0;
        for (int j = 0; j < SENSE_LINES; j++)
        begin
            c   = 2 * j + int'(line_odd);
            pos = int'(line_row) * COLS + c;
            if (!in_sense[j] && c < COLS)
            begin
                acc_line[KEY_W'(pos)] = 1'b1;
            end
        end
    end

    assign acc_new = ((in_line == '0) ? '0 : acc_reg) | acc_line;

    // Modifier flags from the bitmap as it stands
    always_comb
    begin
        for (int m = 0; m < MOD_COUNT; m++)
        begin
            held_flags[m] = held(bitmap_reg, mod_idx_reg[m]);
        end
    end

    assign evt_pos = KEY_W'(int'(km.row) * COLS + int'(km.col));

    // Sub-units
    kmct_keymap u_keymap (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (km_start),
        .key_num (in_code[KEY_NUM_W-1:0]),
        .res     (km)
    );

    kmct_scanner u_scanner (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (scan_load),
        .diff    (acc_new ^ bitmap_reg),
        .new_map (acc_new),
        .advance (scan_adv),
        .stat    (scan)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode_reg)
                    begin
                        if (!key_zero)
                        begin
                            state_next = ST_DIVIDE;
                        end
                    end
                    else if (in_line == LAST_LINE && acc_new != bitmap_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (km.done)
                begin
                    state_next = km.hit ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_adv && !scan.more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        km_start      = 1'b0;
        scan_load     = 1'b0;
        scan_adv      = 1'b0;
        out_load      = 1'b0;
        out_last_in   = 1'b1;
        out_row_in    = evt_row_reg;
        out_col_in    = evt_col_reg;
        out_pr_in     = evt_pr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                km_start      = in_fire && mode_reg && !key_zero;
                scan_load     = in_fire && !mode_reg && (in_line == LAST_LINE);
            end
            ST_DIVIDE:
            begin
            end
            ST_EMIT:
            begin
                out_load = slot_free;
            end
            ST_SCAN:
            begin
                scan_adv    = !scan.hit || slot_free;
                out_load    = scan.hit && slot_free;
                out_last_in = !scan.more;
                out_row_in  = scan.row;
                out_col_in  = scan.col;
                out_pr_in   = scan.pressed;
            end
            default:
            begin
            end
        endcase
    end

    // Bitmap and accumulator updates
    always_comb
    begin
        acc_next    = acc_reg;
        bitmap_next = bitmap_reg;
        if (in_fire && !mode_reg)
        begin
            acc_next = acc_new;
            if (in_line == LAST_LINE)
            begin
                bitmap_next = acc_new;
            end
        end
        if (state_reg == ST_DIVIDE && km.done && km.hit)
        begin
            bitmap_next[evt_pos] = evt_pr_reg;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            bitmap_reg    <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int m = 0; m < MOD_COUNT; m++)
            begin
                mod_idx_reg[m] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            bitmap_reg <= bitmap_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_fire)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MODE:  mode_reg       <= cfg_data[0];
                    CFG_FN:    mod_idx_reg[0] <= cfg_data;
                    CFG_SHIFT: mod_idx_reg[1] <= cfg_data;
                    CFG_CTRL:  mod_idx_reg[2] <= cfg_data;
                    CFG_OPT:   mod_idx_reg[3] <= cfg_data;
                    CFG_ALT:   mod_idx_reg[4] <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    // Event and output payload
    always_ff @(posedge clk)
    begin
        if (km_start)
        begin
            evt_pr_reg <= in_code[PRESS_BIT];
        end
        if (state_reg == ST_DIVIDE && km.done)
        begin
            evt_row_reg <= km.row;
            evt_col_reg <= km.col;
        end
        if (out_load)
        begin
            out_data_reg <= {held_flags, out_pr_in, out_col_in, out_row_in};
            out_last_reg <= out_last_in;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

    // Checks: after a non-final beat leaves, the scan goes on or its final beat is waiting
    `KMCT_ASSERT_NEXT(a_more_follows, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast && state_reg == ST_SCAN, state_reg == ST_SCAN || (m_axis_tvalid && m_axis_tlast))
    `KMCT_ASSERT_IMPLIES(a_divide_busy, clk, rst_n, state_reg == ST_DIVIDE, km.busy)
    `KMCT_ASSERT_IMPLIES(a_idle_scan_empty, clk, rst_n, state_reg == ST_IDLE, !scan.hit && !scan.more)
    `KMCT_ASSERT_IMPLIES(a_out_source, clk, rst_n, $rose(m_axis_tvalid), $past(state_reg) == ST_EMIT || $past(state_reg) == ST_SCAN)

endmodule

// ===== verif/tb_keyboard_matrix_change_tracker.sv =====
// Self-checking testbench for the keyboard matrix change tracker: scan lines, event bytes, modifiers.
module tb_keyboard_matrix_change_tracker
    import kmct_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CODE_W-1:0] PRESS_FLAG = 8'h80;

    // One key change as it should leave the block
    typedef struct {
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic                 pressed;
        logic [MOD_COUNT-1:0] held;   // fn, shift, ctrl, opt, alt from bit 0 up
        logic                 last;
    } key_change_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [IDX_W-1:0]     cfg_data;

    // Predictor state
    logic [COLS-1:0]  pressed_map [ROWS];
    logic [COLS-1:0]  scan_acc [ROWS];
    logic             event_mode;
    logic [IDX_W-1:0] mod_idx [MOD_COUNT];
    key_change_t      pending_changes [$];

    logic [SENSE_LINES-1:0] prev_sense [SCAN_LINES];
    string mod_name [MOD_COUNT] = '{"fn_held", "shift_held", "ctrl_held", "opt_held", "alt_held"};
    int    fail_count;
    int    burst_left;
    int    idle_cycles;

    keyboard_matrix_change_tracker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Modifier state as read from the bitmap; rows past the matrix read released
    function automatic logic modifier_held(logic [IDX_W-1:0] idx);
        int r;
        int c;
        r = idx / COLS;
        c = idx % COLS;
        if (r >= ROWS)
            return 1'b0;
        return pressed_map[r][c];
    endfunction

    function automatic void queue_change(int r, int c, logic pr);
        key_change_t ev;
        ev.row     = ROW_W'(r);
        ev.col     = COL_W'(c);
        ev.pressed = pr;
        for (int k = 0; k < MOD_COUNT; k++)
            ev.held[k] = modifier_held(mod_idx[k]);
        ev.last = 1'b0;
        pending_changes.push_back(ev);
    endfunction

    // Work out the key changes caused by one accepted input beat
    function automatic void track_keys(logic [LINE_W-1:0] line, logic [SENSE_LINES-1:0] sense,
                                       logic [CODE_W-1:0] code);
        int              n_before;
        int              r;
        int              c;
        int              n;
        logic [COLS-1:0] old_map [ROWS];
        n_before = pending_changes.size();
        if (!event_mode)
        begin
            r = ROWS - 1 - (line % 4);
            if (line == 0)
                for (int i = 0; i < ROWS; i++)
                    scan_acc[i] = '0;
            for (int j = 0; j < SENSE_LINES; j++)
            begin
                c = (line < 4) ? 2 * j + 1 : 2 * j;
                if (!sense[j] && c < COLS)
                    scan_acc[r][c] = 1'b1;
            end
            // Last line: the finished scan replaces the bitmap
            if (line == LAST_LINE)
            begin
                old_map = pressed_map;
                pressed_map = scan_acc;
                for (int i = 0; i < ROWS; i++)
                    for (int k = 0; k < COLS; k++)
                        if (old_map[i][k] != pressed_map[i][k])
                            queue_change(i, k, pressed_map[i][k]);
            end
        end
        else if (code[KEY_NUM_W-1:0] != 0)
        begin
            n = code[KEY_NUM_W-1:0] - 1;
            c = 2 * (n / 10) + (((n % 10) > 3) ? 1 : 0);
            r = (n % 10) % 4;
            if (c < COLS)
            begin
                pressed_map[r][c] = code[PRESS_BIT];
                queue_change(r, c, code[PRESS_BIT]);
            end
        end
        if (pending_changes.size() > n_before)
            pending_changes[pending_changes.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic check_change_beat();
        key_change_t ev;
        if (pending_changes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected output beat, tdata %h", m_axis_tdata));
            return;
        end
        ev = pending_changes.pop_front();
        check_field("key_row", int'(m_axis_tdata[ROW_W-1:0]), int'(ev.row));
        check_field("key_col", int'(m_axis_tdata[ROW_W +: COL_W]), int'(ev.col));
        check_field("pressed", int'(m_axis_tdata[ROW_W+COL_W]), int'(ev.pressed));
        for (int k = 0; k < MOD_COUNT; k++)
            check_field(mod_name[k], int'(m_axis_tdata[ROW_W+COL_W+1+k]), int'(ev.held[k]));
        check_field("last", int'(m_axis_tlast), int'(ev.last));
        check_field("padding", int'(m_axis_tdata[OUT_W-1:OUT_FIELDS_W]), 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_change_beat();
    end

    // Watchdog: cycles in which no channel moves a beat
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stalls: m_axis_tready follows a randomly picked style that changes between runs of cycles
    // ------------------------------------------------------------------
    initial
    begin
        int style;
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        forever
        begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(20, 80))
            begin
                @(negedge clk);
                phase++;
                case (style)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(0, 1));
                    2: m_axis_tready = (phase % 3 == 0);
                    default: m_axis_tready = (phase % 16) >= 12;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one input beat; the sender runs in bursts with random gaps between
    task automatic send_beat(logic [LINE_W-1:0] line, logic [SENSE_LINES-1:0] sense,
                             logic [CODE_W-1:0] code);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        @(negedge clk);
        s_axis_tdata  = IN_W'({code, sense, line});
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        track_keys(line, sense, code);
        burst_left--;
    endtask

    // Wait for every expected change, then let a scan or a mapping in flight finish
    task automatic drain_changes();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending_changes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [IDX_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MODE:  event_mode = value[0];
            CFG_FN:    mod_idx[0] = value;
            CFG_SHIFT: mod_idx[1] = value;
            CFG_CTRL:  mod_idx[2] = value;
            CFG_OPT:   mod_idx[3] = value;
            CFG_ALT:   mod_idx[4] = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_modifiers(logic [IDX_W-1:0] fn, logic [IDX_W-1:0] shift,
                                   logic [IDX_W-1:0] ctrl, logic [IDX_W-1:0] opt,
                                   logic [IDX_W-1:0] alt);
        cfg_write(CFG_FN, fn);
        cfg_write(CFG_SHIFT, shift);
        cfg_write(CFG_CTRL, ctrl);
        cfg_write(CFG_OPT, opt);
        cfg_write(CFG_ALT, alt);
    endtask

    // Modifier index, weighted towards the corners of the matrix
    function automatic logic [IDX_W-1:0] pick_modifier();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return IDX_W'(KEYS - 1);
            default: return IDX_W'($urandom_range(0, KEYS - 1));
        endcase
    endfunction

    // Sense levels for one line: mostly released, few changes against the last scan
    function automatic logic [SENSE_LINES-1:0] pick_sense(logic [SENSE_LINES-1:0] prev);
        case ($urandom_range(0, 5))
            0: return '1;
            1: return ~(SENSE_LINES'(1) << $urandom_range(0, SENSE_LINES - 1));
            2: return SENSE_LINES'($urandom);
            3: return prev ^ (SENSE_LINES'(1) << $urandom_range(0, SENSE_LINES - 1));
            default: return prev;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Matrix mode: full press, a scan missing line zero that leaves it unchanged, partial release
    task automatic test_matrix_directed();
        drain_changes();
        cfg_write(CFG_MODE, '0);
        // fn top-left, shift bottom-right, ctrl mid, opt past the matrix, alt row 2
        write_modifiers('0, IDX_W'(KEYS - 1), 6'd15, '1, 6'd28);
        // Every key down; the event byte must be ignored
        for (int i = 0; i < SCAN_LINES; i++)
            send_beat(LINE_W'(i), '0, 8'hFF);
        // Lines without line zero: accumulator still full, so no change
        for (int i = 4; i < SCAN_LINES; i++)
            send_beat(LINE_W'(i), '1, 8'h00);
        // Fresh scan with two lines partly held
        for (int i = 0; i < SCAN_LINES; i++)
            send_beat(LINE_W'(i), (i == 3) ? 7'h55 : (i == 6) ? 7'h2A : 7'h7F,
                      CODE_W'($urandom));
        for (int i = 0; i < SCAN_LINES; i++)
            prev_sense[i] = (i == 3) ? 7'h55 : (i == 6) ? 7'h2A : 7'h7F;
    endtask

    // Event mode: empty bytes, range edges, press and release
    task automatic test_event_directed();
        logic [CODE_W-1:0] codes [12] = '{8'h00, 8'h80, 8'h81, 8'hC6, 8'h47, 8'hFF, 8'h7F,
                                          8'h8B, 8'hB8, 8'h01, 8'h46, 8'h0B};
        drain_changes();
        cfg_write(CFG_MODE, 6'd1);
        write_modifiers(6'd0, 6'd13, 6'd2, 6'd29, IDX_W'(KEYS - 1));
        // Scan fields carry noise that must be ignored
        foreach (codes[i])
            send_beat(LINE_W'($urandom), SENSE_LINES'($urandom), codes[i]);
    endtask

    // Mostly well-formed scans, some stray lines in between
    task automatic test_random_matrix(int scans);
        logic [SENSE_LINES-1:0] s;
        drain_changes();
        cfg_write(CFG_MODE, '0);
        write_modifiers(pick_modifier(), pick_modifier(), pick_modifier(), pick_modifier(),
                        pick_modifier());
        for (int n = 0; n < scans; n++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(LINE_W'($urandom), SENSE_LINES'($urandom), CODE_W'($urandom));
            end
            else
            begin
                for (int i = 0; i < SCAN_LINES; i++)
                begin
                    s = pick_sense(prev_sense[i]);
                    prev_sense[i] = s;
                    send_beat(LINE_W'(i), s, CODE_W'($urandom));
                end
            end
        end
    endtask

    // Event bytes: mostly keys inside the matrix, some empty or out of range
    task automatic test_random_event(int beats);
        logic [CODE_W-1:0] code;
        drain_changes();
        cfg_write(CFG_MODE, 6'd1);
        write_modifiers(pick_modifier(), pick_modifier(), pick_modifier(), pick_modifier(),
                        pick_modifier());
        repeat (beats)
        begin
            case ($urandom_range(0, 9))
                0: code = ($urandom_range(0, 1) == 1) ? PRESS_FLAG : '0;
                1: code = CODE_W'($urandom);
                default:
                begin
                    code = CODE_W'($urandom_range(1, 70));
                    code[PRESS_BIT] = 1'($urandom_range(0, 1));
                end
            endcase
            send_beat(LINE_W'($urandom), SENSE_LINES'($urandom), code);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        burst_left    = 0;
        event_mode    = 1'b0;
        for (int i = 0; i < ROWS; i++)
        begin
            pressed_map[i] = '0;
            scan_acc[i]    = '0;
        end
        for (int k = 0; k < MOD_COUNT; k++)
            mod_idx[k] = '0;
        for (int i = 0; i < SCAN_LINES; i++)
            prev_sense[i] = '1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_matrix_directed();
        test_event_directed();
        test_random_matrix(6);
        test_random_event(25);
        test_random_matrix(6);
        test_random_event(15);
        drain_changes();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== keyboard_matrix_change_tracker.f =====
+incdir+src
src/kmct_pkg.sv
src/kmct_keymap.sv
src/kmct_scanner.sv
src/keyboard_matrix_change_tracker.sv
verif/tb_keyboard_matrix_change_tracker.sv
